### rtl/volume_fade_ramp_controller_defines.svh
// ----------------------------------------------------------------------------
// Volume fade ramp controller: assertion macros
// Clocked assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VOLUME_FADE_RAMP_CONTROLLER_DEFINES_SVH
`define VOLUME_FADE_RAMP_CONTROLLER_DEFINES_SVH

// checked outside reset only
`define VFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every edge, reset included
`define VFR_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/vfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_pkg
// Types, codes and the gain ROM shared by the fade ramp controller.
// ----------------------------------------------------------------------------
package vfr_pkg;

  localparam int IDX_W     = 7;
  localparam int WORD_W    = 32;
  localparam int ROM_DEPTH = 128;
  localparam int CFG_W     = 2;

  typedef enum logic [2:0] {
    OP_FADE_OUT   = 3'd0,
    OP_FADE_IN    = 3'd1,
    OP_SET_LEVEL  = 3'd2,
    OP_READ_LEVEL = 3'd3,
    OP_STEP_UP    = 3'd4,
    OP_STEP_DOWN  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FADE_OUT,
    ST_FADE_IN,
    ST_SINGLE
  } state_t;

  localparam logic [CFG_W-1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [CFG_W-1:0] CFG_FLOOR_INDEX = 2'd1;
  localparam logic [CFG_W-1:0] CFG_FLOOR_WORD  = 2'd2;

  localparam logic [4:0]        STEP_SIZE_RST   = 5'd4;
  localparam logic [IDX_W-1:0]  FLOOR_INDEX_RST = 7'd114;
  localparam logic [WORD_W-1:0] FLOOR_WORD_RST  = 32'h0000_001A;

  // search status handed from the search unit to the sequencer
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } srch_t;

  localparam logic [WORD_W-1:0] GAIN_ROM [ROM_DEPTH] = '{
    32'h07ECA9CD, 32'h07100C4D, 32'h064B6CAD, 32'h059C2F01, 32'h05000000, 32'h0474CD1B,
    32'h04000000, 32'h038A2BAC, 32'h0327A01A, 32'h02CFCC01, 32'h02818508, 32'h023BC147,
    32'h02000000, 32'h01C62940, 32'h0194C583, 32'h0168C0C5, 32'h0141857E, 32'h011E8E6A,
    32'h00F11B69, 32'h00D6E30C, 32'h00CADDC7, 32'h00B4CE07, 32'h00A12477, 32'h008F9E4C,
    32'h00800000, 32'h00721482, 32'h0065AC8C, 32'h005A9DF7, 32'h0050C335, 32'h0047FACC,
    32'h00400000, 32'h00392CED, 32'h0032F52C, 32'h002D6A86, 32'h00287A26, 32'h00241346,
    32'h00200000, 32'h001CA7D7, 32'h00198A13, 32'h0016C310, 32'h00144960, 32'h0012149A,
    32'h00100000, 32'h000E5CA1, 32'h000CCCCC, 32'h000B6873, 32'h000A2ADA, 32'h00090FCB,
    32'h00080000, 32'h000732AE, 32'h00066A4A, 32'h0005B7B1, 32'h00051884, 32'h00048AA7,
    32'h00040000, 32'h00039B87, 32'h00033718, 32'h0002DD95, 32'h00028DCE, 32'h000246B4,
    32'h00020000, 32'h0001CEDC, 32'h00019C86, 32'h00016FA9, 32'h000147AE, 32'h0001240B,
    32'h00010000, 32'h0000E7FA, 32'h0000CEC0, 32'h0000B844, 32'h0000A43A, 32'h0000925E,
    32'h00008000, 32'h00007443, 32'h0000679F, 32'h00005C5A, 32'h0000524F, 32'h0000495B,
    32'h00004000, 32'h00003A45, 32'h000033EF, 32'h00002E49, 32'h00002940, 32'h000024C4,
    32'h00002000, 32'h00001D34, 32'h00001A07, 32'h00001732, 32'h000014AC, 32'h0000126D,
    32'h00001000, 32'h00000EA3, 32'h00000D0B, 32'h00000BA0, 32'h00000A5C, 32'h00000800,
    32'h00000689, 32'h00000531, 32'h00000400, 32'h00000346, 32'h0000029A, 32'h00000200,
    32'h000001A4, 32'h0000014D, 32'h00000109, 32'h000000D2, 32'h000000A7, 32'h00000084,
    32'h00000069, 32'h00000053, 32'h00000042, 32'h00000034, 32'h0000002A, 32'h00000021,
    32'h0000001A,
    32'h0000001A, 32'h0000001A, 32'h0000001A, 32'h0000001A, 32'h0000001A, 32'h0000001A,
    32'h0000001A, 32'h0000001A, 32'h0000001A, 32'h0000001A, 32'h0000001A, 32'h0000001A,
    32'h0000001A
  };

  function automatic logic [WORD_W-1:0] rom_word(input logic [IDX_W-1:0] i);
    return GAIN_ROM[i];
  endfunction

endpackage

### rtl/vfr_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_search
// Linear search of the gain ROM, one compare per cycle, first match wins.
// ----------------------------------------------------------------------------
module vfr_search #(
  parameter int DEPTH = 115
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vfr_pkg::WORD_W-1:0] word,
  output vfr_pkg::srch_t             status
);

  localparam logic [vfr_pkg::IDX_W-1:0] LAST_IDX = vfr_pkg::IDX_W'(DEPTH - 1);

  logic                      busy;
  logic                      done;
  logic                      hit;
  logic [vfr_pkg::IDX_W-1:0] ptr;
  logic [vfr_pkg::IDX_W-1:0] idx;
  logic                      match;

  assign match = (vfr_pkg::rom_word(ptr) == word);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ptr  <= '0;
      end else if (busy) begin
        if (match || ptr == LAST_IDX) begin
          busy <= 1'b0;
          done <= 1'b1;
          hit  <= match;
          idx  <= ptr;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
    end
  end

  // result stays valid after done until the next start
  assign status.done = done;
  assign status.hit  = hit;
  assign status.idx  = idx;

endmodule

### rtl/volume_fade_ramp_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_fade_ramp_controller
// Master gain controller: table search, fades, set/read level and single steps.
// ----------------------------------------------------------------------------
// Fade_in and set_level produce their results straight from the accepted input beat;
//   fade_out, read_level and step ops first run the serial ROM search.
// Fades then give one result per cycle while out_ready is high, up to MAX_FADE_STEPS.
// Throughput: one item at a time; in_ready returns once the last result is registered.
// Reset: registers return to step 4, floor index 114, floor word 0x1A, indexes 0.
module volume_fade_ramp_controller #(
  parameter int TABLE_DEPTH    = 115,
  parameter int MAX_FADE_STEPS = 30
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 op,
  input  logic [vfr_pkg::WORD_W-1:0] gain_word,
  input  logic [6:0]                 level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [vfr_pkg::WORD_W-1:0] out_gain,
  output logic [vfr_pkg::IDX_W-1:0]  gain_index,
  output logic [6:0]                 level_out,
  output logic                       matched,
  output logic                       last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vfr_pkg::CFG_W-1:0]  cfg_index,
  input  logic [31:0]                cfg_data
);

  localparam int K_W = $clog2(MAX_FADE_STEPS + 1);
  localparam logic [K_W-1:0]            K_LAST   = K_W'(MAX_FADE_STEPS - 1);
  localparam logic [vfr_pkg::IDX_W-1:0] LAST_IDX = vfr_pkg::IDX_W'(TABLE_DEPTH - 1);
  localparam logic [7:0]                DEPTH8   = 8'(TABLE_DEPTH);

  // configuration
  logic [4:0]                 step_size;
  logic [vfr_pkg::IDX_W-1:0]  floor_index;
  logic [vfr_pkg::WORD_W-1:0] floor_word;

  // sequencer and item state
  vfr_pkg::state_t            state, state_next;
  vfr_pkg::op_t               op_r;
  logic [vfr_pkg::WORD_W-1:0] word_r;
  logic [6:0]                 level_r;
  logic [vfr_pkg::IDX_W-1:0]  cur, cur_next;
  logic [vfr_pkg::IDX_W-1:0]  start_idx, start_next;
  logic [K_W-1:0]             k, k_next;

  vfr_pkg::srch_t             srch;
  logic                       srch_start;

  // shared add/sub unit
  logic [7:0]                 alu_a, alu_b;
  logic                       alu_sub;
  logic [8:0]                 alu_res;

  logic [4:0]                 step_eff;
  logic [vfr_pkg::IDX_W-1:0]  fl;
  logic [vfr_pkg::IDX_W-1:0]  base;
  logic                       fout_end, fin_end, k_end;
  logic                       in_acc, ld;

  // result being formed
  logic [vfr_pkg::WORD_W-1:0] res_gain;
  logic [vfr_pkg::IDX_W-1:0]  res_idx;
  logic [6:0]                 res_lvl;
  logic                       res_match, res_last;

  assign in_ready  = (state == vfr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  assign step_eff = (step_size == '0) ? 5'd1 : step_size;
  assign fl       = (floor_index > LAST_IDX) ? LAST_IDX : floor_index;
  assign base     = srch.hit ? srch.idx : cur;

  vfr_search #(.DEPTH(TABLE_DEPTH)) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (srch_start),
    .word   (word_r),
    .status (srch)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      vfr_pkg::ST_FADE_OUT: begin
        alu_a = {1'b0, cur};
        alu_b = {3'b000, step_eff};
      end
      vfr_pkg::ST_FADE_IN: begin
        alu_a   = {1'b0, cur};
        alu_b   = {3'b000, step_eff};
        alu_sub = 1'b1;
      end
      vfr_pkg::ST_SINGLE: begin
        case (op_r)
          vfr_pkg::OP_SET_LEVEL: begin
            alu_a   = DEPTH8;
            alu_b   = {1'b0, level_r};
            alu_sub = 1'b1;
          end
          vfr_pkg::OP_STEP_UP: begin
            alu_a   = {1'b0, base};
            alu_b   = 8'd1;
            alu_sub = 1'b1;
          end
          vfr_pkg::OP_STEP_DOWN: begin
            alu_a = {1'b0, base};
            alu_b = 8'd1;
          end
          default: begin
            alu_a = {1'b0, base};
          end
        endcase
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

  // fade ends: floor reached going down, start index reached coming back (signed)
  assign fout_end = (alu_res[7:0] >= {1'b0, fl});
  assign fin_end  = alu_res[8] || (alu_res[7:0] <= {1'b0, start_idx});
  assign k_end    = (k == K_LAST);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vfr_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            vfr_pkg::OP_FADE_IN:    state_next = vfr_pkg::ST_FADE_IN;
            vfr_pkg::OP_SET_LEVEL:  state_next = vfr_pkg::ST_SINGLE;
            vfr_pkg::OP_FADE_OUT,
            vfr_pkg::OP_READ_LEVEL,
            vfr_pkg::OP_STEP_UP,
            vfr_pkg::OP_STEP_DOWN:  state_next = vfr_pkg::ST_SEARCH;
            default:                state_next = vfr_pkg::ST_IDLE;
          endcase
        end
      end
      vfr_pkg::ST_SEARCH: begin
        if (srch.done) begin
          state_next = (op_r == vfr_pkg::OP_FADE_OUT) ? vfr_pkg::ST_FADE_OUT
                                                      : vfr_pkg::ST_SINGLE;
        end
      end
      vfr_pkg::ST_FADE_OUT: begin
        if (ld && (fout_end || k_end)) state_next = vfr_pkg::ST_IDLE;
      end
      vfr_pkg::ST_FADE_IN: begin
        if (ld && (fin_end || k_end)) state_next = vfr_pkg::ST_IDLE;
      end
      vfr_pkg::ST_SINGLE: begin
        if (ld) state_next = vfr_pkg::ST_IDLE;
      end
      default: state_next = vfr_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    ld         = 1'b0;
    srch_start = 1'b0;
    cur_next   = cur;
    start_next = start_idx;
    k_next     = k;
    res_gain   = '0;
    res_idx    = '0;
    res_lvl    = '0;
    res_match  = 1'b0;
    res_last   = 1'b1;
    case (state)
      vfr_pkg::ST_IDLE: begin
        k_next = '0;
        srch_start = in_acc && (op == vfr_pkg::OP_FADE_OUT || op == vfr_pkg::OP_READ_LEVEL ||
                                op == vfr_pkg::OP_STEP_UP || op == vfr_pkg::OP_STEP_DOWN);
      end
      vfr_pkg::ST_SEARCH: begin
        if (srch.done && op_r == vfr_pkg::OP_FADE_OUT) begin
          cur_next   = base;
          start_next = base;
        end
      end
      vfr_pkg::ST_FADE_OUT: begin
        ld        = !out_valid || out_ready;
        res_match = srch.hit;
        if (fout_end) begin
          res_gain = floor_word;
          res_idx  = fl;
        end else begin
          res_idx  = alu_res[6:0];
          res_gain = vfr_pkg::rom_word(res_idx);
          res_last = k_end;
        end
        res_lvl = 7'(DEPTH8 - {1'b0, res_idx});
        if (ld) begin
          cur_next = res_idx;
          k_next   = k + 1'b1;
        end
      end
      vfr_pkg::ST_FADE_IN: begin
        ld = !out_valid || out_ready;
        if (fin_end) begin
          res_idx = start_idx;
        end else begin
          res_idx  = alu_res[6:0];
          res_last = k_end;
        end
        res_gain = vfr_pkg::rom_word(res_idx);
        res_lvl  = 7'(DEPTH8 - {1'b0, res_idx});
        if (ld) begin
          cur_next = res_idx;
          k_next   = k + 1'b1;
        end
      end
      vfr_pkg::ST_SINGLE: begin
        ld = !out_valid || out_ready;
        case (op_r)
          vfr_pkg::OP_SET_LEVEL: begin
            if ({1'b0, level_r} >= DEPTH8) begin
              res_idx = '0;
            end else if (alu_res[7:0] > {1'b0, LAST_IDX}) begin
              res_idx = LAST_IDX;
            end else begin
              res_idx = alu_res[6:0];
            end
            if (ld) cur_next = res_idx;
          end
          vfr_pkg::OP_STEP_UP: begin
            res_match = srch.hit;
            res_idx   = (base != '0) ? alu_res[6:0] : base;
            if (ld) cur_next = res_idx;
          end
          vfr_pkg::OP_STEP_DOWN: begin
            res_match = srch.hit;
            res_idx   = (base < LAST_IDX) ? alu_res[6:0] : base;
            if (ld) cur_next = res_idx;
          end
          default: begin
            // read level: state untouched, word echoed
            res_match = srch.hit;
            res_idx   = base;
          end
        endcase
        if (op_r == vfr_pkg::OP_READ_LEVEL) begin
          res_gain = word_r;
          res_lvl  = srch.hit ? 7'(DEPTH8 - {1'b0, srch.idx}) : 7'd0;
        end else begin
          res_gain = vfr_pkg::rom_word(res_idx);
          res_lvl  = 7'(DEPTH8 - {1'b0, res_idx});
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= vfr_pkg::ST_IDLE;
      out_valid   <= 1'b0;
      cur         <= '0;
      start_idx   <= '0;
      k           <= '0;
      step_size   <= vfr_pkg::STEP_SIZE_RST;
      floor_index <= vfr_pkg::FLOOR_INDEX_RST;
      floor_word  <= vfr_pkg::FLOOR_WORD_RST;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      start_idx <= start_next;
      k         <= k_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vfr_pkg::CFG_STEP_SIZE:   step_size   <= cfg_data[4:0];
          vfr_pkg::CFG_FLOOR_INDEX: floor_index <= cfg_data[6:0];
          vfr_pkg::CFG_FLOOR_WORD:  floor_word  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= vfr_pkg::op_t'(op);
      word_r  <= gain_word;
      level_r <= level;
    end
    if (ld) begin
      out_gain   <= res_gain;
      gain_index <= res_idx;
      level_out  <= res_lvl;
      matched    <= res_match;
      last       <= res_last;
    end
  end

endmodule

### rtl/vfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_checker
// Port-level checks on the fade ramp controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "volume_fade_ramp_controller_defines.svh"

module vfr_checker #(
  parameter int TABLE_DEPTH = 115
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [2:0]                 op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vfr_pkg::WORD_W-1:0] out_gain,
  input logic [vfr_pkg::IDX_W-1:0]  gain_index,
  input logic                       last
);

  localparam logic [vfr_pkg::IDX_W-1:0] LAST_IDX = vfr_pkg::IDX_W'(TABLE_DEPTH - 1);

  `VFR_ASSERT_ANY(a_reset_idle, rst |=> (!out_valid && in_ready), "not idle after reset")

  // a real op clears in_ready in the cycle after it is accepted
  `VFR_ASSERT(a_busy_after_op, (in_valid && in_ready && op <= vfr_pkg::OP_STEP_DOWN) |=> !in_ready, "ready right after op")

  // mid-fade beat pending means the fade still owns the block
  `VFR_ASSERT(a_fade_busy, (out_valid && !last) |-> !in_ready, "ready while fade in flight")

  `VFR_ASSERT(a_index_range, out_valid |-> (gain_index <= LAST_IDX), "index past table end")

  `VFR_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_gain) && $stable(gain_index)), "stalled beat changed")

endmodule

bind volume_fade_ramp_controller vfr_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_vfr_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: volume fade ramp controller testbench
// Drives commands and register writes through valid/ready channels. A
// scoreboard class predicts every gain beat from its own copy of the gain
// table, registers and index state, and checks each output beat in order.
// The directed part is followed by random phases with different idle mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE      = 115 + 30 + 8;
  localparam int STALL_LIMIT = 2000;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [31:0] gain;
    logic [6:0]  idx;
    logic [6:0]  lvl;
    logic        match;
    logic        fin;
  } gain_beat_t;

  class fade_scoreboard;
    localparam int DEPTH      = 115;
    localparam int LAST_IDX   = 114;
    localparam int FADE_STEPS = 30;

    logic [31:0] ramp [DEPTH];
    logic [4:0]  step_size;
    logic [6:0]  floor_index;
    logic [31:0] floor_word;
    logic [6:0]  cur_idx;
    logic [6:0]  start_idx;
    gain_beat_t  pending [$];
    int          errors;

    function new();
      ramp = '{
        32'h07ECA9CD, 32'h07100C4D, 32'h064B6CAD, 32'h059C2F01, 32'h05000000, 32'h0474CD1B,
        32'h04000000, 32'h038A2BAC, 32'h0327A01A, 32'h02CFCC01, 32'h02818508, 32'h023BC147,
        32'h02000000, 32'h01C62940, 32'h0194C583, 32'h0168C0C5, 32'h0141857E, 32'h011E8E6A,
        32'h00F11B69, 32'h00D6E30C, 32'h00CADDC7, 32'h00B4CE07, 32'h00A12477, 32'h008F9E4C,
        32'h00800000, 32'h00721482, 32'h0065AC8C, 32'h005A9DF7, 32'h0050C335, 32'h0047FACC,
        32'h00400000, 32'h00392CED, 32'h0032F52C, 32'h002D6A86, 32'h00287A26, 32'h00241346,
        32'h00200000, 32'h001CA7D7, 32'h00198A13, 32'h0016C310, 32'h00144960, 32'h0012149A,
        32'h00100000, 32'h000E5CA1, 32'h000CCCCC, 32'h000B6873, 32'h000A2ADA, 32'h00090FCB,
        32'h00080000, 32'h000732AE, 32'h00066A4A, 32'h0005B7B1, 32'h00051884, 32'h00048AA7,
        32'h00040000, 32'h00039B87, 32'h00033718, 32'h0002DD95, 32'h00028DCE, 32'h000246B4,
        32'h00020000, 32'h0001CEDC, 32'h00019C86, 32'h00016FA9, 32'h000147AE, 32'h0001240B,
        32'h00010000, 32'h0000E7FA, 32'h0000CEC0, 32'h0000B844, 32'h0000A43A, 32'h0000925E,
        32'h00008000, 32'h00007443, 32'h0000679F, 32'h00005C5A, 32'h0000524F, 32'h0000495B,
        32'h00004000, 32'h00003A45, 32'h000033EF, 32'h00002E49, 32'h00002940, 32'h000024C4,
        32'h00002000, 32'h00001D34, 32'h00001A07, 32'h00001732, 32'h000014AC, 32'h0000126D,
        32'h00001000, 32'h00000EA3, 32'h00000D0B, 32'h00000BA0, 32'h00000A5C, 32'h00000800,
        32'h00000689, 32'h00000531, 32'h00000400, 32'h00000346, 32'h0000029A, 32'h00000200,
        32'h000001A4, 32'h0000014D, 32'h00000109, 32'h000000D2, 32'h000000A7, 32'h00000084,
        32'h00000069, 32'h00000053, 32'h00000042, 32'h00000034, 32'h0000002A, 32'h00000021,
        32'h0000001A
      };
      errors      = 0;
      step_size   = 5'd4;
      floor_index = 7'd114;
      floor_word  = 32'h0000_001A;
      cur_idx     = 7'd0;
      start_idx   = 7'd0;
    endfunction

    // first matching entry, DEPTH on a miss
    function int find_word(logic [31:0] w);
      for (int i = 0; i < DEPTH; i++) begin
        if (ramp[i] == w) return i;
      end
      return DEPTH;
    endfunction

    function void push(logic [31:0] g, int i, int lv, bit m, bit fin);
      gain_beat_t b;
      b.gain  = g;
      b.idx   = 7'(i);
      b.lvl   = 7'(lv);
      b.match = m;
      b.fin   = fin;
      pending.push_back(b);
    endfunction

    function void set_reg(logic [vfr_pkg::CFG_W-1:0] idx, logic [31:0] data);
      case (idx)
        vfr_pkg::CFG_STEP_SIZE:   step_size   = data[4:0];
        vfr_pkg::CFG_FLOOR_INDEX: floor_index = data[6:0];
        vfr_pkg::CFG_FLOOR_WORD:  floor_word  = data;
        default: ;
      endcase
    endfunction

    function void note_command(logic [2:0] cmd, logic [31:0] word, logic [6:0] lvl);
      int  step;
      int  fl;
      int  found;
      int  nx;
      int  idx;
      bit  m;
      step  = (step_size == 5'd0) ? 1 : int'(step_size);
      found = find_word(word);
      m     = (found < DEPTH);
      case (cmd)
        vfr_pkg::OP_FADE_OUT: begin
          fl = (floor_index > LAST_IDX) ? LAST_IDX : int'(floor_index);
          if (m) cur_idx = 7'(found);
          start_idx = cur_idx;
          for (int k = 0; k < FADE_STEPS; k++) begin
            nx = int'(cur_idx) + step;
            if (nx >= fl) begin
              cur_idx = 7'(fl);
              push(floor_word, fl, DEPTH - fl, m, 1'b1);
              return;
            end
            cur_idx = 7'(nx);
            push(ramp[nx], nx, DEPTH - nx, m, k == FADE_STEPS - 1);
          end
        end
        vfr_pkg::OP_FADE_IN: begin
          for (int k = 0; k < FADE_STEPS; k++) begin
            // signed compare: a walk below zero ends the fade
            nx = int'(cur_idx) - step;
            if (nx <= int'(start_idx)) begin
              cur_idx = start_idx;
              push(ramp[start_idx], start_idx, DEPTH - start_idx, 1'b0, 1'b1);
              return;
            end
            cur_idx = 7'(nx);
            push(ramp[nx], nx, DEPTH - nx, 1'b0, k == FADE_STEPS - 1);
          end
        end
        vfr_pkg::OP_SET_LEVEL: begin
          if (lvl >= DEPTH) idx = 0;
          else idx = (DEPTH - lvl > LAST_IDX) ? LAST_IDX : DEPTH - lvl;
          cur_idx = 7'(idx);
          push(ramp[idx], idx, DEPTH - idx, 1'b0, 1'b1);
        end
        vfr_pkg::OP_READ_LEVEL: begin
          push(word, m ? found : int'(cur_idx), DEPTH - found, m, 1'b1);
        end
        vfr_pkg::OP_STEP_UP, vfr_pkg::OP_STEP_DOWN: begin
          if (m) cur_idx = 7'(found);
          if (cmd == vfr_pkg::OP_STEP_UP) begin
            if (cur_idx > 0) cur_idx = cur_idx - 7'd1;
          end else begin
            if (cur_idx < LAST_IDX) cur_idx = cur_idx + 7'd1;
          end
          push(ramp[cur_idx], cur_idx, DEPTH - cur_idx, m, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_beat(logic [31:0] g, logic [6:0] i, logic [6:0] lv, logic m, logic fin);
      gain_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat gain=%h idx=%0d", g, i));
      end else begin
        e = pending.pop_front();
        if (g !== e.gain || i !== e.idx || lv !== e.lvl || m !== e.match || fin !== e.fin)
          report($sformatf("got %h/%0d/%0d/%b/%b exp %h/%0d/%0d/%b/%b",
                           g, i, lv, m, fin, e.gain, e.idx, e.lvl, e.match, e.fin));
      end
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [2:0]  op         = 3'd0;
  logic [31:0] gain_word  = 32'd0;
  logic [6:0]  level      = 7'd0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [31:0] out_gain;
  logic [6:0]  gain_index;
  logic [6:0]  level_out;
  logic        matched;
  logic        last;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [vfr_pkg::CFG_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data   = 32'd0;

  fade_scoreboard sb;
  int send_idle  = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  volume_fade_ramp_controller uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .gain_word  (gain_word),
    .level      (level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_gain   (out_gain),
    .gain_index (gain_index),
    .level_out  (level_out),
    .matched    (matched),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // output side: check the accepted beat, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_beat(out_gain, gain_index, level_out, matched, last);
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task send_cmd(logic [2:0] cmd, logic [31:0] word, logic [6:0] lvl);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= cmd;
    gain_word <= word;
    level     <= lvl;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, word, lvl);
  endtask

  task write_reg(logic [vfr_pkg::CFG_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all expected beats, then give spare ops time to retire
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_all(logic [31:0] step, logic [31:0] fl, logic [31:0] fw);
    write_reg(vfr_pkg::CFG_STEP_SIZE, step);
    write_reg(vfr_pkg::CFG_FLOOR_INDEX, fl);
    write_reg(vfr_pkg::CFG_FLOOR_WORD, fw);
  endtask

  function logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 80) return sb.ramp[$urandom_range(114)];
    return $urandom();
  endfunction

  function logic [2:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 20) return vfr_pkg::OP_FADE_OUT;
    if (r < 40) return vfr_pkg::OP_FADE_IN;
    if (r < 55) return vfr_pkg::OP_SET_LEVEL;
    if (r < 70) return vfr_pkg::OP_READ_LEVEL;
    if (r < 82) return vfr_pkg::OP_STEP_UP;
    if (r < 94) return vfr_pkg::OP_STEP_DOWN;
    if (r < 97) return OP_SPARE_6;
    return OP_SPARE_7;
  endfunction

  task run_random(int n, int pause_at);
    int       cnt;
    bit       paused;
    logic [2:0] cmd;
    cnt    = 0;
    paused = 0;
    while (cnt < n) begin
      if (!paused && pause_at >= 0 && cnt >= pause_at) begin
        wait_idle();
        paused = 1;
      end
      if ($urandom_range(99) < 45) begin
        // well-formed ramp: position, fade down, fade back up
        send_cmd(vfr_pkg::OP_SET_LEVEL, $urandom(), 7'($urandom_range(127)));
        send_cmd(vfr_pkg::OP_FADE_OUT, pick_word(), 7'($urandom_range(127)));
        send_cmd(vfr_pkg::OP_FADE_IN, $urandom(), 7'($urandom_range(127)));
        cnt += 3;
      end else begin
        cmd = pick_op();
        send_cmd(cmd, pick_word(), 7'($urandom_range(127)));
        if (cmd != OP_SPARE_6 && cmd != OP_SPARE_7) cnt++;
      end
    end
  endtask

  task run_phase(int s_idle, int r_idle, logic [31:0] step, logic [31:0] fl,
                 logic [31:0] fw, int n, int pause_at);
    wait_idle();
    send_idle  = s_idle;
    recv_stall = r_idle;
    write_all(step, fl, fw);
    run_random(n, pause_at);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    send_cmd(vfr_pkg::OP_SET_LEVEL, 32'h0, 7'd115);
    send_cmd(vfr_pkg::OP_SET_LEVEL, 32'hFFFF_FFFF, 7'd0);
    send_cmd(vfr_pkg::OP_SET_LEVEL, 32'h0, 7'd127);
    send_cmd(vfr_pkg::OP_FADE_OUT, sb.ramp[0], 7'd0);
    send_cmd(vfr_pkg::OP_FADE_IN, 32'h0, 7'd0);
    send_cmd(vfr_pkg::OP_FADE_OUT, 32'hFFFF_FFFF, 7'h7F);
    send_cmd(vfr_pkg::OP_SET_LEVEL, 32'h0, 7'd114);
    send_cmd(vfr_pkg::OP_FADE_IN, 32'h0, 7'd0);         // index would go negative
    send_cmd(vfr_pkg::OP_READ_LEVEL, sb.ramp[24], 7'd0);
    send_cmd(vfr_pkg::OP_READ_LEVEL, 32'h0, 7'd0);
    send_cmd(vfr_pkg::OP_READ_LEVEL, 32'hFFFF_FFFF, 7'h7F);
    send_cmd(vfr_pkg::OP_STEP_UP, sb.ramp[0], 7'd0);     // holds at loudest
    send_cmd(vfr_pkg::OP_STEP_DOWN, sb.ramp[114], 7'd0); // holds at quietest
    send_cmd(vfr_pkg::OP_STEP_UP, 32'h1234_5678, 7'd0);
    send_cmd(vfr_pkg::OP_STEP_DOWN, 32'h0, 7'd0);
    send_cmd(OP_SPARE_6, $urandom(), 7'($urandom_range(127)));
    send_cmd(OP_SPARE_7, $urandom(), 7'($urandom_range(127)));
    send_cmd(vfr_pkg::OP_FADE_OUT, sb.ramp[114], 7'd0);

    // zero step acts as one; floor above the table clamps
    wait_idle();
    write_all(32'd0, 32'd127, 32'hFFFF_FFFF);
    send_cmd(vfr_pkg::OP_FADE_OUT, sb.ramp[0], 7'd0);    // runs out of steps
    send_cmd(vfr_pkg::OP_SET_LEVEL, 32'h0, 7'd1);
    send_cmd(vfr_pkg::OP_FADE_IN, 32'h0, 7'd0);          // runs out of steps
    send_cmd(vfr_pkg::OP_FADE_IN, 32'h0, 7'd0);

    wait_idle();
    write_reg(vfr_pkg::CFG_FLOOR_INDEX, 32'd0);
    send_cmd(vfr_pkg::OP_FADE_OUT, sb.ramp[50], 7'd0);   // straight to the floor
    send_cmd(vfr_pkg::OP_SET_LEVEL, 32'h0, 7'd60);

    run_phase(0, 0, 32'd16, 32'd114, 32'h0, 20, -1);
    run_phase(49, 0, 32'd1, 32'd60, 32'hFFFF_FFFF, 20, 12);
    run_phase(0, 49, 32'd31, 32'd127, $urandom(), 20, -1);
    run_phase(35, 35, $urandom_range(1, 16), $urandom_range(127), $urandom(), 20, 8);

    wait_idle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
